// File: design/lp2c_pkg.sv
// Shared types, constants and the arctangent table of the lidar point converter.
`timescale 1ns / 1ps

package lp2c_pkg;

    // Number of rotation cells in the chain (valid range 8 to 24)
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int STAGE_IDX_W   = $clog2(TABLE_LEN);

    // Field widths
    localparam int DIST_W   = 20;
    localparam int ANGLE_W  = 15;
    localparam int HEIGHT_W = 20;
    localparam int POS_W    = 21;
    localparam int MAXD_W   = 16;

    // Internal widths
    localparam int OFFS_W  = 21;   // signed radial offset
    localparam int GAIN_W  = 25;   // signed gain constant
    localparam int PROD_W  = OFFS_W + GAIN_W;
    localparam int CW      = 32;   // rotation datapath, x, y and residual angle
    localparam int REM_W   = 13;   // angle remainder below a quarter turn
    localparam int ROUND_W = 25;   // rounded component before saturation

    // Stream and register port widths
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 64;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register indexes
    localparam logic REG_MAX_DIST = 1'b0;
    localparam logic [MAXD_W-1:0] MAX_DIST_RESET = 16'd12000;

    // Angle constants in 1/64 degree
    localparam logic [ANGLE_W-1:0] FULL_TURN     = 15'd23040;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN  = 15'd5760;
    localparam logic [ANGLE_W-1:0] HALF_TURN     = 15'd11520;
    localparam logic [ANGLE_W-1:0] THREE_QUARTER = 15'd17280;

    // Gain compensation in Q24 and rounding constants
    localparam logic signed [GAIN_W-1:0] GAIN_Q24   = 25'sd10188014;
    localparam logic signed [PROD_W-1:0] PROD_ROUND = 46'sd32768;
    localparam logic signed [CW-1:0]     OUT_ROUND  = 32'sd128;

    localparam logic signed [ROUND_W-1:0] POS_MAX = 25'sd1048575;
    localparam logic signed [ROUND_W-1:0] POS_MIN = -25'sd1048576;

    // Quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // One beat in flight through the rotation chain
    typedef struct packed {
        logic                       ok;
        logic [1:0]                 quad;
        logic signed [HEIGHT_W-1:0] height;
        logic signed [CW-1:0]       x;
        logic signed [CW-1:0]       y;
        logic signed [CW-1:0]       z;
    } lp2c_item_t;

    // atan(2^-i) in units of 2^-22 degree
    function automatic logic signed [CW-1:0] atan_entry(input logic [STAGE_IDX_W-1:0] idx);
        logic signed [CW-1:0] v;
        begin
            case (idx)
                5'd0:    v = 32'sd188743680;
                5'd1:    v = 32'sd111421900;
                5'd2:    v = 32'sd58872272;
                5'd3:    v = 32'sd29884485;
                5'd4:    v = 32'sd15000234;
                5'd5:    v = 32'sd7507429;
                5'd6:    v = 32'sd3754631;
                5'd7:    v = 32'sd1877430;
                5'd8:    v = 32'sd938729;
                5'd9:    v = 32'sd469366;
                5'd10:   v = 32'sd234683;
                5'd11:   v = 32'sd117342;
                5'd12:   v = 32'sd58671;
                5'd13:   v = 32'sd29335;
                5'd14:   v = 32'sd14668;
                5'd15:   v = 32'sd7334;
                5'd16:   v = 32'sd3667;
                5'd17:   v = 32'sd1833;
                5'd18:   v = 32'sd917;
                5'd19:   v = 32'sd458;
                5'd20:   v = 32'sd229;
                5'd21:   v = 32'sd115;
                5'd22:   v = 32'sd57;
                5'd23:   v = 32'sd29;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// File: design/lp2c_prep.sv
// Front end: range check, radial offset, angle reduction and gain multiply.
`timescale 1ns / 1ps

module lp2c_prep
    import lp2c_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [MAXD_W-1:0]          max_dist,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [DIST_W-1:0]          in_dist,
    input  logic [ANGLE_W-1:0]         in_angle,
    input  logic signed [HEIGHT_W-1:0] in_height,
    output logic                       out_valid,
    input  logic                       out_ready,
    output lp2c_item_t                 out_item
);

    logic                       s1_valid_reg;
    logic                       s1_ok_reg, s1_ok_next;
    logic signed [OFFS_W-1:0]   s1_offs_reg, s1_offs_next;
    logic [1:0]                 s1_quad_reg, s1_quad_next;
    logic [REM_W-1:0]           s1_rem_reg, s1_rem_next;
    logic signed [HEIGHT_W-1:0] s1_height_reg;

    logic                       s2_valid_reg;
    logic                       s2_ok_reg;
    logic signed [PROD_W-1:0]   s2_prod_reg, s2_prod_next;
    logic [1:0]                 s2_quad_reg;
    logic [REM_W-1:0]           s2_rem_reg;
    logic signed [HEIGHT_W-1:0] s2_height_reg;

    logic                       adv1, adv2;
    logic [ANGLE_W-1:0]         ang_red;
    logic [ANGLE_W-1:0]         quad_base;
    logic [ANGLE_W-1:0]         rem_full;
    logic signed [PROD_W-1:0]   x_round;

    // Each stage moves when empty or when the next one takes its beat
    assign adv2     = !s2_valid_reg || out_ready;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    // Range check, offset from rotation center, split angle into quadrant and remainder
    always_comb begin
        s1_ok_next   = (in_dist <= {max_dist, 4'b0000});
        s1_offs_next = $signed({2'b00, max_dist, 3'b000}) - $signed({1'b0, in_dist});
        ang_red      = (in_angle >= FULL_TURN) ? (in_angle - FULL_TURN) : in_angle;
        if (ang_red >= THREE_QUARTER) begin
            s1_quad_next = QUAD_3;
            quad_base    = THREE_QUARTER;
        end else if (ang_red >= HALF_TURN) begin
            s1_quad_next = QUAD_2;
            quad_base    = HALF_TURN;
        end else if (ang_red >= QUARTER_TURN) begin
            s1_quad_next = QUAD_1;
            quad_base    = QUARTER_TURN;
        end else begin
            s1_quad_next = QUAD_0;
            quad_base    = '0;
        end
        rem_full    = ang_red - quad_base;
        s1_rem_next = rem_full[REM_W-1:0];
    end

    // Scale the offset by the CORDIC gain
    assign s2_prod_next = s1_offs_reg * GAIN_Q24;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (adv1) s1_valid_reg <= in_valid;
            if (adv2) s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            s1_ok_reg     <= s1_ok_next;
            s1_offs_reg   <= s1_offs_next;
            s1_quad_reg   <= s1_quad_next;
            s1_rem_reg    <= s1_rem_next;
            s1_height_reg <= in_height;
        end
        if (adv2) begin
            s2_ok_reg     <= s1_ok_reg;
            s2_prod_reg   <= s2_prod_next;
            s2_quad_reg   <= s1_quad_reg;
            s2_rem_reg    <= s1_rem_reg;
            s2_height_reg <= s1_height_reg;
        end
    end

    // Round the scaled offset to 8 fraction bits and seed the rotation
    assign x_round = (s2_prod_reg + PROD_ROUND) >>> 16;

    always_comb begin
        out_item.ok     = s2_ok_reg;
        out_item.quad   = s2_quad_reg;
        out_item.height = s2_height_reg;
        out_item.x      = x_round[CW-1:0];
        out_item.y      = '0;
        out_item.z      = {3'b000, s2_rem_reg, 16'h0000};
    end

    assign out_valid = s2_valid_reg;

endmodule

// File: design/lp2c_cell.sv
// One rotation cell of the CORDIC chain.
`timescale 1ns / 1ps

module lp2c_cell
    import lp2c_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [STAGE_IDX_W-1:0] stage_idx,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  lp2c_item_t             in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output lp2c_item_t             out_item
);

    logic                 valid_reg;
    lp2c_item_t           item_reg, item_next;
    logic signed [CW-1:0] x_in, y_in, z_in;
    logic signed [CW-1:0] dx, dy, ang_step;
    logic                 adv;

    assign adv      = !valid_reg || out_ready;
    assign in_ready = adv;

    // Rotate toward zero residual angle with floor shifts
    always_comb begin
        x_in      = in_item.x;
        y_in      = in_item.y;
        z_in      = in_item.z;
        dx        = y_in >>> stage_idx;
        dy        = x_in >>> stage_idx;
        ang_step  = atan_entry(stage_idx);
        item_next = in_item;
        if (!z_in[CW-1]) begin
            item_next.x = x_in - dx;
            item_next.y = y_in + dy;
            item_next.z = z_in - ang_step;
        end else begin
            item_next.x = x_in + dx;
            item_next.y = y_in - dy;
            item_next.z = z_in + ang_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// File: design/lp2c_post.sv
// Back end: rounding, quadrant turn, saturation and the output register.
`timescale 1ns / 1ps

module lp2c_post
    import lp2c_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lp2c_item_t           in_item,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser
);

    logic                      valid_reg;
    logic [M_TDATA_W-1:0]      tdata_reg, tdata_next;
    logic                      tuser_reg;
    logic                      adv;
    logic signed [CW-1:0]      x_sh, y_sh;
    logic signed [ROUND_W-1:0] rx, ry, ox, oy, sx, sy;

    assign adv      = !valid_reg || m_tready;
    assign in_ready = adv;

    // Drop the 8 fraction bits with round half up
    assign x_sh = (in_item.x + OUT_ROUND) >>> 8;
    assign y_sh = (in_item.y + OUT_ROUND) >>> 8;
    assign rx   = x_sh[ROUND_W-1:0];
    assign ry   = y_sh[ROUND_W-1:0];

    // Turn by whole quadrants, then clamp to the output range
    always_comb begin
        case (in_item.quad)
            QUAD_1: begin
                ox = -ry;
                oy = rx;
            end
            QUAD_2: begin
                ox = -rx;
                oy = -ry;
            end
            QUAD_3: begin
                ox = ry;
                oy = -rx;
            end
            default: begin
                ox = rx;
                oy = ry;
            end
        endcase
        if (ox > POS_MAX)      sx = POS_MAX;
        else if (ox < POS_MIN) sx = POS_MIN;
        else                   sx = ox;
        if (oy > POS_MAX)      sy = POS_MAX;
        else if (oy < POS_MIN) sy = POS_MIN;
        else                   sy = oy;
        if (in_item.ok) begin
            tdata_next = {2'b00, in_item.height, sy[POS_W-1:0], sx[POS_W-1:0]};
        end else begin
            tdata_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tdata_reg <= tdata_next;
            tuser_reg <= in_item.ok;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

endmodule

// File: design/lidar_polar_to_cartesian_core.sv
// Top level of the lidar polar to Cartesian converter.
`timescale 1ns / 1ps
//
// Turns one lidar sample (distance, turntable angle, head height) into one
// 3-D point. Samples enter on the s_ stream, points leave on the m_ stream,
// one point per sample, in order.
// A sample whose distance exceeds 16 * max_distance_mm comes out with
// m_tuser low and all coordinates zero; otherwise x and y are the offset
// (8 * max_distance_mm - distance) rotated by the angle, and z is the height.
// max_distance_mm is written over the register port at address 0 and resets to
// 12000; the user must write it only while no sample is in flight, as the
// block does not enforce this. A beat passes through two front-end stages,
// one rotation cell per CORDIC stage and the output register.
// Throughput: one beat per cycle while the receiver takes every beat; the chain
// of rotation cells carries one sample per cell and each cell hands its beat
// on whenever the next stage can take it.
// When the receiver stalls, the output register holds its beat and the chain
// keeps filling its empty stages; s_tready falls only when every stage holds
// a beat. Reset empties the whole chain and restores the register.
//
module lidar_polar_to_cartesian_core
    import lp2c_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Sample stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // distance[19:0], angle[34:20], height[54:35]
    // Point stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // x_pos[20:0], y_pos[41:21], z_pos[61:42]
    output logic                  m_tuser,   // valid_res[0]
    // Register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [MAXD_W-1:0] max_dist_reg;
    logic              cfg_write;

    lp2c_item_t chain_item  [CORDIC_STAGES+1];
    logic       chain_valid [CORDIC_STAGES+1];
    logic       chain_ready [CORDIC_STAGES+1];

    // Register port: always ready, one register at index zero
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_dist_reg <= MAX_DIST_RESET;
        end else if (cfg_write && (paddr[2] == REG_MAX_DIST)) begin
            max_dist_reg <= pwdata[MAXD_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_MAX_DIST) prdata = {{(APB_DATA_W-MAXD_W){1'b0}}, max_dist_reg};
        else                          prdata = '0;
    end

    lp2c_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .max_dist  (max_dist_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_dist   (s_tdata[DIST_W-1:0]),
        .in_angle  (s_tdata[DIST_W+ANGLE_W-1:DIST_W]),
        .in_height (s_tdata[DIST_W+ANGLE_W+HEIGHT_W-1:DIST_W+ANGLE_W]),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_item  (chain_item[0])
    );

    // Chain of rotation cells, one per CORDIC stage
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        lp2c_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .stage_idx (STAGE_IDX_W'(g)),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_item   (chain_item[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_item  (chain_item[g+1])
        );
    end

    lp2c_post u_post (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (chain_valid[CORDIC_STAGES]),
        .in_ready (chain_ready[CORDIC_STAGES]),
        .in_item  (chain_item[CORDIC_STAGES]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // A rejected sample carries no coordinates
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("rejected point carries nonzero coordinates");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output beat valid right after reset");

    // A register write lands in the limit register
    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_write && (paddr[2] == REG_MAX_DIST)) |=> (max_dist_reg == $past(pwdata[MAXD_W-1:0])))
        else $error("limit register write lost");

    // The input side stalls only when the first stage holds a beat it cannot pass on
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (u_prep.s1_valid_reg == 1'b1))
        else $error("input stalled with an empty first stage");

endmodule

// File: tb/sv/lidar_point_checker.sv
// Checker for the lidar point converter: predicts each point and compares the output stream.
`timescale 1ns / 1ps

module lidar_point_checker
    import lp2c_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // distance[19:0], angle[34:20], height[54:35]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // x_pos[20:0], y_pos[41:21], z_pos[61:42]
    input  logic                  m_tuser,   // valid_res[0]
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,
    output int                    mismatches,
    output int                    points_pending
);

    localparam longint POS_HI  = 64'sd1048575;
    localparam longint POS_LO  = -64'sd1048576;

    // atan(2^-i) in units of 2^-22 degree
    localparam longint ATAN_STEP [TABLE_LEN] = '{
        188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
        3754631, 1877430, 938729, 469366, 234683, 117342,
        58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29
    };

    typedef struct packed {
        logic                       ok;
        logic signed [POS_W-1:0]    x;
        logic signed [POS_W-1:0]    y;
        logic signed [HEIGHT_W-1:0] z;
    } point_t;

    point_t                point_q[$];
    point_t                want;
    point_t                got;
    logic [MAXD_W-1:0]     max_mm;

    // Clamp a rotated component to the coordinate range
    function automatic longint clip_pos(input longint v);
        if (v > POS_HI)
            return POS_HI;
        if (v < POS_LO)
            return POS_LO;
        return v;
    endfunction

    // Work out the point one sample must become under the given maximum
    function automatic point_t predict_point(input logic [DIST_W-1:0] dist_val,
                                             input logic [ANGLE_W-1:0] ang,
                                             input logic signed [HEIGHT_W-1:0] hgt,
                                             input logic [MAXD_W-1:0] mm);
        point_t     p;
        longint     offs, turn, xa, ya, za, dx, dy, rx, ry, ox, oy;
        logic [1:0] quad;
        int         i;
        p = '0;
        if (longint'(dist_val) > longint'(mm) * 16)
            return p;
        offs = longint'(mm) * 8 - longint'(dist_val);
        turn = longint'(ang);
        if (turn >= longint'(FULL_TURN))
            turn -= longint'(FULL_TURN);
        quad = 2'(turn / longint'(QUARTER_TURN));
        za = (turn % longint'(QUARTER_TURN)) * 65536;
        xa = (offs * longint'(GAIN_Q24) + 32768) >>> 16;
        ya = 0;
        // rotate toward zero residual angle
        for (i = 0; i < CORDIC_STAGES && i < TABLE_LEN; i++) begin
            dx = ya >>> i;
            dy = xa >>> i;
            if (za >= 0) begin
                xa -= dx;
                ya += dy;
                za -= ATAN_STEP[i];
            end else begin
                xa += dx;
                ya -= dy;
                za += ATAN_STEP[i];
            end
        end
        rx = (xa + 128) >>> 8;
        ry = (ya + 128) >>> 8;
        // turn by whole quarters
        case (quad)
            QUAD_1: begin
                ox = -ry;
                oy = rx;
            end
            QUAD_2: begin
                ox = -rx;
                oy = -ry;
            end
            QUAD_3: begin
                ox = ry;
                oy = -rx;
            end
            default: begin
                ox = rx;
                oy = ry;
            end
        endcase
        p.ok = 1'b1;
        p.x  = POS_W'(clip_pos(ox));
        p.y  = POS_W'(clip_pos(oy));
        p.z  = hgt;
        return p;
    endfunction

    initial begin
        mismatches     = 0;
        points_pending = 0;
        max_mm         = MAX_DIST_RESET;
    end

    // Predict on each input beat, track the register, compare on each output beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            max_mm = MAX_DIST_RESET;
            point_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                point_q.push_back(predict_point(s_tdata[19:0], s_tdata[34:20],
                                                s_tdata[54:35], max_mm));
            if (psel && penable && pready && paddr[APB_ADDR_W-1:2] == REG_MAX_DIST) begin
                if (pwrite) begin
                    max_mm = pwdata[MAXD_W-1:0];
                end else if (prdata != APB_DATA_W'(max_mm)) begin
                    mismatches++;
                    $display("%0t: register read expected %0d, got %0d", $time, max_mm, prdata);
                end
            end
            if (m_tvalid && m_tready) begin
                got.ok = m_tuser;
                got.x  = m_tdata[20:0];
                got.y  = m_tdata[41:21];
                got.z  = m_tdata[61:42];
                if (point_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: point expected none, got ok=%0b x=%0d y=%0d z=%0d",
                             $time, got.ok, got.x, got.y, got.z);
                end else begin
                    want = point_q.pop_front();
                    if (got.ok != want.ok || got.x != want.x || got.y != want.y
                            || got.z != want.z) begin
                        mismatches++;
                        $display("%0t: point expected ok=%0b x=%0d y=%0d z=%0d,%s",
                                 $time, want.ok, want.x, want.y, want.z, " got");
                        $display("%0t:   got ok=%0b x=%0d y=%0d z=%0d",
                                 $time, got.ok, got.x, got.y, got.z);
                    end
                end
            end
        end
        points_pending = point_q.size();
    end

endmodule

// File: tb/sv/lidar_polar_to_cartesian_core_tb.sv
// Testbench top for the lidar point converter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module lidar_polar_to_cartesian_core_tb;
    import lp2c_pkg::*;

    localparam int RAND_PER_PHASE = 160;
    localparam int HOLD_CYCLES    = 120;
    localparam int MAX_DIST_VAL   = 1048575;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_MOSTLY,
        RDY_RARELY,
        RDY_COIN
    } ready_mode_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;   // distance[19:0], angle[34:20], height[54:35]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // x_pos[20:0], y_pos[41:21], z_pos[61:42]
    logic                  m_tuser;          // valid_res[0]
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    mismatches;
    int                    points_pending;

    logic [S_TDATA_W-1:0]  sample_q[$];
    int                    burst_left = 0;
    int                    gap_left   = 0;
    int                    hold_left  = 0;
    int                    stretch_left = 0;
    ready_mode_t           ready_mode = RDY_ALWAYS;
    logic                  want_hold  = 1'b0;
    logic                  hold_done  = 1'b0;
    logic [MAXD_W-1:0]     cur_mm;

    localparam logic [APB_ADDR_W-1:0] MAXD_ADDR  = {REG_MAX_DIST, 2'b00};
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = {~REG_MAX_DIST, 2'b00};

    lidar_polar_to_cartesian_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    lidar_point_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .mismatches     (mismatches),
        .points_pending (points_pending)
    );

    always #5 aclk = ~aclk;

    // Give up well past the slowest correct run
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Present queued samples in bursts with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (sample_q.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= sample_q.pop_front();
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 48);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Stall the point stream in stretches of varying pressure, once for a long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready     <= 1'b0;
            hold_left    <= 0;
            stretch_left <= 0;
        end else if (want_hold && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            if (stretch_left == 0) begin
                stretch_left <= $urandom_range(8, 48);
                ready_mode   <= ready_mode_t'($urandom_range(0, 3));
            end else begin
                stretch_left <= stretch_left - 1;
            end
            case (ready_mode)
                RDY_ALWAYS: m_tready <= 1'b1;
                RDY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                RDY_RARELY: m_tready <= ($urandom_range(0, 3) == 0);
                default:    m_tready <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    function automatic void push_sample(input int d, input int a, input logic [HEIGHT_W-1:0] h);
        sample_q.push_back({1'b0, h, ANGLE_W'(a), DIST_W'(d)});
    endfunction

    // Pick a distance mostly inside the limit, some at its edge, some anywhere
    function automatic int pick_distance(input logic [MAXD_W-1:0] mm);
        int lim;
        int d;
        lim = int'(mm) * 16;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: d = $urandom_range(0, lim);
            6: d = lim - 1 + $urandom_range(0, 2);
            default: d = $urandom_range(0, MAX_DIST_VAL);
        endcase
        if (d < 0)
            d = 0;
        if (d > MAX_DIST_VAL)
            d = MAX_DIST_VAL;
        return d;
    endfunction

    task automatic push_random(input int count);
        int a;
        repeat (count) begin
            a = ($urandom_range(0, 9) == 0) ? $urandom_range(int'(FULL_TURN), 32767)
                                            : $urandom_range(0, int'(FULL_TURN) - 1);
            push_sample(pick_distance(cur_mm), a, HEIGHT_W'($urandom));
        end
    endtask

    // Distances of zero, at the limit, just past it, at zero offset and at the field top
    task automatic push_edges();
        int lim;
        lim = int'(cur_mm) * 16;
        push_sample(0, $urandom_range(0, 32767), HEIGHT_W'($urandom));
        push_sample(lim, $urandom_range(0, 32767), HEIGHT_W'($urandom));
        if (lim < MAX_DIST_VAL)
            push_sample(lim + 1, $urandom_range(0, 32767), HEIGHT_W'($urandom));
        push_sample(int'(cur_mm) * 8, $urandom_range(0, 32767), HEIGHT_W'($urandom));
        push_sample(MAX_DIST_VAL, $urandom_range(0, 32767), HEIGHT_W'($urandom));
    endtask

    task automatic reg_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_read(input logic [APB_ADDR_W-1:0] addr);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Hold until every sample is in and every point is out
    task automatic wait_drained();
        while (sample_q.size() != 0 || s_tvalid || points_pending != 0)
            @(posedge aclk);
    endtask

    // Set a new maximum, read it back, then run edges and random samples under it, optionally with a long output hold
    task automatic run_phase(input logic [MAXD_W-1:0] mm, input logic hold);
        reg_write(MAXD_ADDR, {16'($urandom), mm});
        cur_mm = mm;
        reg_read(MAXD_ADDR);
        if (hold)
            want_hold = 1'b1;
        push_edges();
        push_random(RAND_PER_PHASE);
        wait_drained();
    endtask

    initial begin
        int angles[12];
        angles = '{0, 1, 5759, 5760, 11519, 11520, 17280, 23039, 23040, 23041, 32767, 12345};
        cur_mm = MAX_DIST_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        reg_read(MAXD_ADDR);

        // directed: every quadrant boundary, wrapped angles, height and distance extremes
        foreach (angles[k])
            push_sample(0, angles[k], HEIGHT_W'($urandom));
        push_sample(192000, int'(QUARTER_TURN), HEIGHT_W'(524287));
        push_sample(192001, 0, HEIGHT_W'(-524288));
        push_sample(MAX_DIST_VAL, 32767, HEIGHT_W'(-1));
        push_sample(96000, 100, HEIGHT_W'(5));
        push_sample(150000, int'(HALF_TURN) + 1, HEIGHT_W'(-524288));
        push_sample(1, int'(THREE_QUARTER) - 1, HEIGHT_W'(524287));
        push_random(RAND_PER_PHASE);
        wait_drained();

        run_phase(16'd65535, 1'b1);
        run_phase(16'd0, 1'b0);
        run_phase(16'd1, 1'b0);
        run_phase(MAXD_W'($urandom_range(1, 65535)), 1'b0);
        // a write to an unmapped address must leave the maximum alone
        reg_write(SPARE_ADDR, $urandom);
        reg_read(MAXD_ADDR);
        push_random(20);
        wait_drained();
        run_phase(16'd16, 1'b0);
        run_phase(MAXD_W'($urandom_range(1, 65535)), 1'b0);
        run_phase(MAX_DIST_RESET, 1'b0);

        repeat (CORDIC_STAGES + 8) @(posedge aclk);
        if (mismatches == 0 && points_pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
